// File: hw/rtl/srpg_pkg.sv
`default_nettype none

package srpg_pkg;

    localparam int STEP_COUNT_BITS = 16;
    localparam int CMP_W = ((STEP_COUNT_BITS > 8) ? STEP_COUNT_BITS : 8) + 2;
    localparam int DIV_STEPS = 8;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam logic [7:0] HALF_PERIOD_RESET = 8'd255;

    typedef logic [STEP_COUNT_BITS-1:0] count_t;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_MOVE = 2'd1,
        OP_LOAD = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef struct packed {
        logic exec;
        logic div_load;
        logic div_step;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic move_start;
    } ctrl_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/srpg_ctrl.sv
`default_nettype none

module srpg_ctrl (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    input  wire srpg_pkg::ctrl_stat_t  stat,
    output srpg_pkg::ctrl_cmd_t        cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_COMMIT
    } state_t;

    state_t                          state_reg;
    logic [srpg_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic                            m_valid_reg;
    logic                            in_fire;

    assign s_ready = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign in_fire = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd.exec     = in_fire && !stat.move_start;
        cmd.div_load = in_fire && stat.move_start;
        cmd.div_step = (state_reg == ST_DIV);
        cmd.commit   = (state_reg == ST_COMMIT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if ((in_fire && !stat.move_start) || (state_reg == ST_COMMIT)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_fire && stat.move_start) begin
                        state_reg <= ST_DIV;
                        cnt_reg   <= '0;
                    end
                end
                ST_DIV: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == srpg_pkg::DIV_CNT_W'(srpg_pkg::DIV_STEPS - 1)) begin
                        state_reg <= ST_COMMIT;
                    end
                end
                ST_COMMIT: begin
                    state_reg <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/srpg_datapath.sv
`default_nettype none

module srpg_datapath (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire srpg_pkg::ctrl_cmd_t  cmd,
    output srpg_pkg::ctrl_stat_t      stat,
    input  wire logic [1:0]           s_op,
    input  wire logic [15:0]          s_step_count,
    input  wire logic [7:0]           s_pulse_max,
    input  wire logic [7:0]           s_pulse_min,
    input  wire logic [7:0]           s_ramp_length,
    input  wire logic                 s_direction,
    input  wire logic signed [15:0]   s_new_position,
    input  wire logic                 cfg_wr,
    input  wire logic                 cfg_data,
    output logic                      m_step_level,
    output logic                      m_direction_level,
    output logic                      m_enable_n,
    output logic                      m_busy_res,
    output logic signed [15:0]        m_position,
    output logic                      m_move_done
);

    localparam int CW = srpg_pkg::CMP_W;

    // move and position state
    logic [15:0]       pos_reg;
    srpg_pkg::count_t  done_cnt_reg;
    srpg_pkg::count_t  total_reg;
    logic [7:0]        ramp_reg;
    logic [7:0]        half_reg;
    logic [7:0]        delta_reg;
    logic [7:0]        floor_reg;
    logic [7:0]        tick_reg;
    logic              level_reg;
    logic              moving_reg;
    logic              pyramid_reg;
    logic              dir_reg;
    logic              enable_reg;

    // latched move command and divider
    srpg_pkg::count_t  op_n_reg;
    logic [7:0]        op_tmax_reg;
    logic [7:0]        op_tmin_reg;
    logic [7:0]        op_nr_reg;
    logic              op_dir_reg;
    logic [7:0]        rem_reg;
    logic [7:0]        quo_reg;

    // result word
    logic              o_step_reg;
    logic              o_dir_reg;
    logic              o_en_n_reg;
    logic              o_busy_reg;
    logic [15:0]       o_pos_reg;
    logic              o_done_reg;

    srpg_pkg::op_t     op;
    logic [8:0]        rem_sh;
    logic              rem_ge;
    logic [7:0]        half_np;
    logic [CW-1:0]     s_ext;
    logic [CW-1:0]     r_ext;
    logic [CW-1:0]     t_ext;
    logic [CW-1:0]     h_ext;
    logic [8:0]        tick_sum;
    logic [8:0]        limit;
    logic [15:0]       pos_x;
    srpg_pkg::count_t  done_x;
    logic [7:0]        tick_x;
    logic              level_x;
    logic              moving_x;
    logic [7:0]        half_x;
    logic              fin_x;
    logic [7:0]        dt_c;
    logic              pyr_c;
    logic [7:0]        half_c;

    assign op = srpg_pkg::op_t'(s_op);
    assign stat.move_start = (op == srpg_pkg::OP_MOVE) && !moving_reg;

    // restoring divide, one quotient bit per step
    assign rem_sh = {rem_reg, quo_reg[7]};
    assign rem_ge = rem_sh >= {1'b0, op_nr_reg};

    // half-period of the next step
    always_comb begin
        s_ext   = CW'(done_cnt_reg);
        r_ext   = CW'(ramp_reg);
        t_ext   = CW'(total_reg);
        h_ext   = CW'(total_reg >> 1);
        half_np = half_reg;
        if (!pyramid_reg) begin
            if (s_ext < r_ext) begin
                half_np = half_reg - delta_reg;
            end else if (s_ext <= t_ext - r_ext) begin
                half_np = floor_reg;
            end else begin
                half_np = half_reg + delta_reg;
            end
        end else begin
            if (s_ext < h_ext) begin
                half_np = half_reg - delta_reg;
            end else if (s_ext > h_ext) begin
                half_np = half_reg + delta_reg;
            end
        end
    end

    // tick, load and ignored ops
    always_comb begin
        pos_x    = pos_reg;
        done_x   = done_cnt_reg;
        tick_x   = tick_reg;
        level_x  = level_reg;
        moving_x = moving_reg;
        half_x   = half_reg;
        fin_x    = 1'b0;
        tick_sum = {1'b0, tick_reg} + 9'd1;
        limit    = ((half_reg > 8'd1) ? {1'b0, half_reg} : 9'd1) + 9'd1;
        unique case (op)
            srpg_pkg::OP_LOAD: begin
                pos_x = s_new_position;
            end
            srpg_pkg::OP_TICK: begin
                if (moving_reg) begin
                    if (tick_sum >= limit) begin
                        tick_x  = 8'd0;
                        level_x = !level_reg;
                        if (level_x) begin
                            done_x = done_cnt_reg + 1'b1;
                            pos_x  = dir_reg ? (pos_reg + 16'd1) : (pos_reg - 16'd1);
                        end else if (done_cnt_reg >= total_reg) begin
                            moving_x = 1'b0;
                            fin_x    = 1'b1;
                        end else begin
                            half_x = half_np;
                        end
                    end else begin
                        tick_x = tick_sum[7:0];
                    end
                end
            end
            srpg_pkg::OP_MOVE, srpg_pkg::OP_NONE: begin
            end
            default: begin
            end
        endcase
    end

    // move set-up from the latched command
    always_comb begin
        dt_c  = (op_nr_reg != 8'd0) ? quo_reg : 8'd0;
        pyr_c = !(CW'(op_n_reg) > (CW'(op_nr_reg) << 1));
        if (!pyr_c) begin
            half_c = (op_nr_reg == 8'd0) ? op_tmin_reg : op_tmax_reg;
        end else begin
            half_c = ((op_n_reg >> 1) == '0) ? (op_tmax_reg + dt_c) : op_tmax_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            done_cnt_reg <= '0;
            total_reg    <= '0;
            ramp_reg     <= '0;
            half_reg     <= srpg_pkg::HALF_PERIOD_RESET;
            delta_reg    <= '0;
            floor_reg    <= '0;
            tick_reg     <= '0;
            level_reg    <= 1'b0;
            moving_reg   <= 1'b0;
            pyramid_reg  <= 1'b0;
            dir_reg      <= 1'b0;
            enable_reg   <= 1'b1;
        end else begin
            if (cfg_wr) begin
                enable_reg <= cfg_data;
            end
            if (cmd.exec) begin
                pos_reg      <= pos_x;
                done_cnt_reg <= done_x;
                tick_reg     <= tick_x;
                level_reg    <= level_x;
                moving_reg   <= moving_x;
                half_reg     <= half_x;
            end else if (cmd.commit) begin
                delta_reg    <= dt_c;
                ramp_reg     <= op_nr_reg;
                floor_reg    <= op_tmin_reg;
                total_reg    <= op_n_reg;
                done_cnt_reg <= '0;
                dir_reg      <= op_dir_reg;
                pyramid_reg  <= pyr_c;
                half_reg     <= half_c;
                tick_reg     <= '0;
                level_reg    <= 1'b0;
                moving_reg   <= (op_n_reg != '0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            op_n_reg    <= srpg_pkg::count_t'(s_step_count);
            op_tmax_reg <= s_pulse_max;
            op_tmin_reg <= s_pulse_min;
            op_nr_reg   <= s_ramp_length;
            op_dir_reg  <= s_direction;
            rem_reg     <= '0;
            quo_reg     <= s_pulse_max - s_pulse_min;
        end else if (cmd.div_step) begin
            rem_reg <= rem_ge ? 8'(rem_sh - {1'b0, op_nr_reg}) : rem_sh[7:0];
            quo_reg <= {quo_reg[6:0], rem_ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            o_step_reg <= moving_x && level_x;
            o_dir_reg  <= dir_reg;
            o_en_n_reg <= !enable_reg;
            o_busy_reg <= moving_x;
            o_pos_reg  <= pos_x;
            o_done_reg <= fin_x;
        end else if (cmd.commit) begin
            o_step_reg <= 1'b0;
            o_dir_reg  <= op_dir_reg;
            o_en_n_reg <= !enable_reg;
            o_busy_reg <= (op_n_reg != '0);
            o_pos_reg  <= pos_reg;
            o_done_reg <= 1'b0;
        end
    end

    assign m_step_level      = o_step_reg;
    assign m_direction_level = o_dir_reg;
    assign m_enable_n        = o_en_n_reg;
    assign m_busy_res        = o_busy_reg;
    assign m_position        = $signed(o_pos_reg);
    assign m_move_done       = o_done_reg;

endmodule

`default_nettype wire

// File: hw/rtl/stepper_ramp_pulse_generator.sv
// Step-pulse generator with a trapezoid or pyramid speed profile. Every accepted
// word (timebase tick, move start or position load) returns exactly one result word that
// shows the pins, busy flag, position and move-done flag after that word. The result of a
// tick, a position load, or a move start while busy is registered the cycle after acceptance.
// A move start while idle first runs eight iterations of the restoring divider that computes
// the 8-bit speed step, then a set-up state.
// One word is in work at a time; a result that waits on the output holds off the input,
// and the next word can be accepted in the cycle in which that result is taken. The
// driver_enable register is written through cfg_valid/cfg_data,
// always ready, and should only be changed while the block is idle.
`default_nettype none

module stepper_ramp_pulse_generator (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [1:0]          s_op,
    input  wire logic [15:0]         s_step_count,
    input  wire logic [7:0]          s_pulse_max,
    input  wire logic [7:0]          s_pulse_min,
    input  wire logic [7:0]          s_ramp_length,
    input  wire logic                s_direction,
    input  wire logic signed [15:0]  s_new_position,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic                     m_step_level,
    output logic                     m_direction_level,
    output logic                     m_enable_n,
    output logic                     m_busy_res,
    output logic signed [15:0]       m_position,
    output logic                     m_move_done,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_data
);

    srpg_pkg::ctrl_cmd_t   cmd;
    srpg_pkg::ctrl_stat_t  stat;

    assign cfg_ready = 1'b1;

    srpg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    srpg_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .stat              (stat),
        .s_op              (s_op),
        .s_step_count      (s_step_count),
        .s_pulse_max       (s_pulse_max),
        .s_pulse_min       (s_pulse_min),
        .s_ramp_length     (s_ramp_length),
        .s_direction       (s_direction),
        .s_new_position    (s_new_position),
        .cfg_wr            (cfg_valid && cfg_ready),
        .cfg_data          (cfg_data),
        .m_step_level      (m_step_level),
        .m_direction_level (m_direction_level),
        .m_enable_n        (m_enable_n),
        .m_busy_res        (m_busy_res),
        .m_position        (m_position),
        .m_move_done       (m_move_done)
    );

endmodule

`default_nettype wire

// File: hw/rtl/srpg_checker.sv
`default_nettype none

module srpg_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         m_valid,
    input wire logic         m_ready,
    input wire logic         m_step_level,
    input wire logic         m_busy_res,
    input wire logic [15:0]  m_position,
    input wire logic         m_move_done
);

    // no result word right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word valid after reset");

    // step pin is only driven during a move
    a_step_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_busy_res) |-> !m_step_level)
        else $error("step level high while not busy");

    // a finishing word ends the move with the step pin low
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_move_done) |-> (!m_busy_res && !m_step_level))
        else $error("move done while still busy");

    // stalled result word stays valid and keeps its position
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_position)))
        else $error("stalled result word changed");

endmodule

bind stepper_ramp_pulse_generator srpg_checker u_srpg_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_step_level (m_step_level),
    .m_busy_res   (m_busy_res),
    .m_position   (m_position),
    .m_move_done  (m_move_done)
);

`default_nettype wire
